FILE: rtl/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned MAX_OUT = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } enc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_final;
  } dec_t;

  // One decoded burst: up to three bytes, fin marks the end of the string.
  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    logic [MAX_OUT-1:0][7:0]    bytes;
    logic                       fin;
  } burst_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 4'(c[3:0] + 4'd9);
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

FILE: rtl/upd_front.sv
// Front end: tracks the escape state and turns each request into a burst of decoded bytes.
module upd_front import upd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   enc_valid,
  input  enc_t   enc,
  input  logic   full,
  output logic   enc_stall,
  output logic   push,
  output burst_t burst
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PCT,
    ESC_HEX1
  } esc_t;

  esc_t       mode, mode_next;
  logic [7:0] held, held_next;
  logic       accept;

  assign enc_stall = full;
  assign accept    = enc_valid && !full;

  always_comb begin
    logic [CNT_W-1:0] n;
    logic             brk;
    logic [7:0]       c;
    n         = '0;
    brk       = 1'b0;
    c         = enc.in_byte;
    burst     = '0;
    mode_next = mode;
    held_next = held;

    case (mode)
      ESC_PCT: begin
        if (is_hex(c)) begin
          held_next = c;
          mode_next = ESC_HEX1;
        end else begin
          burst.bytes[n] = CH_PERCENT;
          n = n + 1'b1;
          brk = 1'b1;
        end
      end
      ESC_HEX1: begin
        held_next = '0;
        mode_next = ESC_IDLE;
        if (is_hex(c)) begin
          burst.bytes[n] = {hex_val(held), hex_val(c)};
          n = n + 1'b1;
        end else begin
          burst.bytes[n] = CH_PERCENT;
          n = n + 1'b1;
          burst.bytes[n] = held;
          n = n + 1'b1;
          brk = 1'b1;
        end
      end
      default: brk = 1'b1;
    endcase

    // breaking byte is handled as if no escape were pending
    if (brk) begin
      mode_next = ESC_IDLE;
      if (c == CH_PLUS) begin
        burst.bytes[n] = CH_SPACE;
        n = n + 1'b1;
      end else if (c == CH_PERCENT) begin
        mode_next = ESC_PCT;
      end else begin
        burst.bytes[n] = c;
        n = n + 1'b1;
      end
    end

    // end of string flushes a pending escape literally
    if (enc.is_final) begin
      if (mode_next == ESC_PCT) begin
        burst.bytes[n] = CH_PERCENT;
        n = n + 1'b1;
      end else if (mode_next == ESC_HEX1) begin
        burst.bytes[n] = CH_PERCENT;
        n = n + 1'b1;
        burst.bytes[n] = held_next;
        n = n + 1'b1;
      end
      mode_next = ESC_IDLE;
      held_next = '0;
    end

    burst.cnt = n;
    burst.fin = enc.is_final;
  end

  assign push = accept && (burst.cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ESC_IDLE;
      held <= '0;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

FILE: rtl/upd_queue.sv
// Small register queue of decoded bursts between front and back ends.
module upd_queue import upd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output burst_t head,
  output logic   full,
  output logic   empty
);

  burst_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("upd_queue: push while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("upd_queue: pop while empty");
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.cnt != '0))
    else $error("upd_queue: empty burst stored");
  assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("upd_queue: count overflow");

endmodule

FILE: rtl/upd_back.sv
// Back end: serializes each burst into single bytes behind an output register.
module upd_back import upd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  burst_t head,
  input  logic   empty,
  output logic   pop,
  output logic   dec_valid,
  input  logic   dec_stall,
  output dec_t   dec
);

  logic [CNT_W-1:0] sel;
  logic             load;
  logic             last;

  assign load = !empty && (!dec_valid || !dec_stall);
  assign last = (sel == head.cnt - 1'b1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= '0;
      dec_valid <= 1'b0;
    end else begin
      if (load) begin
        dec_valid <= 1'b1;
        sel       <= last ? '0 : sel + 1'b1;
      end else if (!dec_stall) begin
        dec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec.out_byte  <= head.bytes[sel];
      dec.out_final <= head.fin && last;
    end
  end

endmodule

FILE: rtl/url_percent_decoder.sv
// URL percent decoder: one encoded byte per request in, decoded bytes out.
// Each decoded byte passes through the burst queue and then the output register.
// Throughput: one request per cycle while each yields at most one byte and
// the output is not stalled; a multi-byte request is sent one byte at a time.
// A four-entry burst queue absorbs short output stalls.
// Synchronous reset clears the escape state, the queue and the output valid.
module url_percent_decoder import upd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic enc_valid,
  output logic enc_stall,
  input  enc_t enc,
  output logic dec_valid,
  input  logic dec_stall,
  output dec_t dec
);

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  burst_t burst;
  burst_t head;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .enc       (enc),
    .full      (full),
    .enc_stall (enc_stall),
    .push      (push),
    .burst     (burst)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (burst),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec)
  );

endmodule
